// ===== rtl/gkc_pkg.sv =====
// Shared types and constants for the graph kernel checker.
`timescale 1ns / 1ps

package gkc_pkg;

    localparam int DEFAULT_MAX_VERTICES = 16;

    localparam logic [4:0] NUM_VERTICES_RESET = 5'd16;
    localparam logic [8:0] EDGE_COUNT_MAX     = 9'd511;

    localparam logic [1:0] OP_ADD_EDGE   = 2'd0;
    localparam logic [1:0] OP_ADD_MEMBER = 2'd1;
    localparam logic [1:0] OP_CHECK      = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] src_vertex;
        logic [3:0] dst_vertex;
        logic [3:0] member_vertex;
    } item_t;

    typedef struct packed {
        logic       is_kernel;
        logic [8:0] edge_count;
        logic [4:0] member_count;
    } result_t;

    // Control from the sequencer to the row accumulation unit.
    typedef struct packed {
        logic clear;
        logic step;
        logic member;
    } row_ctrl_t;

endpackage

// ===== rtl/gkc_row_mem.sv =====
// Adjacency row memory with one valid bit per row, so that a clear resets every row together.
`timescale 1ns / 1ps

module gkc_row_mem
    import gkc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_VERTICES,
    parameter int WIDTH = DEFAULT_MAX_VERTICES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A row that was never written since the last clear reads as all zeros.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gkc_row_unit.sv =====
// Accumulates member conflicts and the reach set, one adjacency row per step.
`timescale 1ns / 1ps

module gkc_row_unit
    import gkc_pkg::*;
#(
    parameter int WIDTH = DEFAULT_MAX_VERTICES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  row_ctrl_t        ctrl,
    input  logic [WIDTH-1:0] row,
    input  logic [WIDTH-1:0] member_set,
    output logic             conflict,
    output logic [WIDTH-1:0] reach
);

    logic             conflict_reg;
    logic             conflict_next;
    logic [WIDTH-1:0] reach_reg;
    logic [WIDTH-1:0] reach_next;

    always_comb
    begin
        conflict_next = conflict_reg;
        reach_next    = reach_reg;
        if (ctrl.clear)
        begin
            conflict_next = 1'b0;
            reach_next    = '0;
        end
        else if (ctrl.step && ctrl.member)
        begin
            // A member whose row touches any member breaks independence.
            conflict_next = conflict_reg | (|(row & member_set));
            reach_next    = reach_reg | row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conflict_reg <= 1'b0;
            reach_reg    <= '0;
        end
        else
        begin
            conflict_reg <= conflict_next;
            reach_reg    <= reach_next;
        end
    end

    assign conflict = conflict_reg;
    assign reach    = reach_reg;

endmodule

// ===== rtl/graph_kernel_check.sv =====
// Top level of the directed graph kernel checker: sequencer and output register.
`timescale 1ns / 1ps

// Keeps a directed adjacency matrix over up to MAX_VERTICES vertices, a
// candidate vertex set and a distinct edge count, and on a check transfer
// reports whether the set is a kernel. Adding a member and clearing end in the
// idle state; an edge also passes through the edge state, as the stored row
// is read through the memory's registered read port before it is written
// back. A check walks every adjacency row through that single read port and
// the shared row unit, one row a cycle, then waits in the done state while
// the previous result has not been taken. The input is stalled until the
// current item is finished. Clearing is immediate through per-row valid bits,
// so no sweep follows reset. The configuration port is always ready; the user
// writes it only while the block is idle, which the block does not enforce.
module graph_kernel_check
    import gkc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VERTICES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EDGE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        scan_idx_next;
    logic [IDX_W-1:0]        edge_src_reg;
    logic [IDX_W-1:0]        edge_src_next;
    logic [MAX_VERTICES-1:0] edge_bit_reg;
    logic [MAX_VERTICES-1:0] edge_bit_next;
    logic [MAX_VERTICES-1:0] set_reg;
    logic [MAX_VERTICES-1:0] set_next;
    logic [8:0]              edge_count_reg;
    logic [8:0]              edge_count_next;
    logic [4:0]              member_count_reg;
    logic [4:0]              member_count_next;
    logic [4:0]              num_vertices_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    result_t                 result_reg;
    result_t                 result_next;

    logic [CMP_W-1:0]        n_eff;
    logic [MAX_VERTICES-1:0] active_mask;
    logic                    src_ok;
    logic                    dst_ok;
    logic                    member_ok;
    logic                    kernel_ok;

    logic                    mem_clear;
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic [MAX_VERTICES-1:0] mem_wr_data;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [MAX_VERTICES-1:0] mem_rd_data;

    row_ctrl_t               unit_ctrl;
    logic                    unit_conflict;
    logic [MAX_VERTICES-1:0] unit_reach;

    gkc_row_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gkc_row_unit #(
        .WIDTH (MAX_VERTICES)
    ) u_row_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (unit_ctrl),
        .row        (mem_rd_data),
        .member_set (set_reg),
        .conflict   (unit_conflict),
        .reach      (unit_reach)
    );

    // A register value above the vertex capacity acts as the capacity.
    always_comb
    begin
        if (CMP_W'(num_vertices_reg) > CMP_W'(MAX_VERTICES))
        begin
            n_eff = CMP_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CMP_W'(num_vertices_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            active_mask[i] = (CMP_W'(i) < n_eff);
        end
    end

    assign src_ok    = (CMP_W'(item.src_vertex) < n_eff);
    assign dst_ok    = (CMP_W'(item.dst_vertex) < n_eff);
    assign member_ok = (CMP_W'(item.member_vertex) < n_eff);
    assign kernel_ok = !unit_conflict && ((active_mask & ~set_reg & ~unit_reach) == '0);

    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        edge_src_next     = edge_src_reg;
        edge_bit_next     = edge_bit_reg;
        set_next          = set_reg;
        edge_count_next   = edge_count_reg;
        member_count_next = member_count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        mem_clear         = 1'b0;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = edge_src_reg;
        mem_wr_data       = mem_rd_data | edge_bit_reg;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = '0;
        unit_ctrl         = '0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_ADD_EDGE:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                mem_rd_en     = 1'b1;
                                mem_rd_addr   = IDX_W'(item.src_vertex);
                                edge_src_next = IDX_W'(item.src_vertex);
                                edge_bit_next = MAX_VERTICES'(1) << IDX_W'(item.dst_vertex);
                                state_next    = ST_EDGE;
                            end
                        end
                        OP_ADD_MEMBER:
                        begin
                            if (member_ok && !set_reg[IDX_W'(item.member_vertex)])
                            begin
                                set_next = set_reg
                                    | (MAX_VERTICES'(1) << IDX_W'(item.member_vertex));
                                member_count_next = member_count_reg + 5'd1;
                            end
                        end
                        OP_CHECK:
                        begin
                            mem_rd_en       = 1'b1;
                            mem_rd_addr     = '0;
                            scan_idx_next   = '0;
                            unit_ctrl.clear = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            mem_clear         = 1'b1;
                            set_next          = '0;
                            edge_count_next   = '0;
                            member_count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EDGE:
            begin
                // Only a previously clear bit counts as a new edge.
                if ((mem_rd_data & edge_bit_reg) == '0)
                begin
                    mem_wr_en = 1'b1;
                    if (edge_count_reg != EDGE_COUNT_MAX)
                    begin
                        edge_count_next = edge_count_reg + 9'd1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                unit_ctrl.step   = 1'b1;
                unit_ctrl.member = set_reg[scan_idx_reg];
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_idx_reg + 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next        = 1'b1;
                    result_next.is_kernel    = kernel_ok;
                    result_next.edge_count   = edge_count_reg;
                    result_next.member_count = member_count_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            set_reg          <= '0;
            edge_count_reg   <= '0;
            member_count_reg <= '0;
            num_vertices_reg <= NUM_VERTICES_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            set_reg          <= set_next;
            edge_count_reg   <= edge_count_next;
            member_count_reg <= member_count_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                num_vertices_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        edge_src_reg <= edge_src_next;
        edge_bit_reg <= edge_bit_next;
        result_reg   <= result_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    a_edge_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EDGE |=> state_reg == ST_IDLE)
        else $error("edge update did not return to idle");

    a_check_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.op == OP_CHECK |=> state_reg == ST_SCAN)
        else $error("accepted check did not start a scan");

    a_scan_advances: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && scan_idx_reg != LAST_IDX
        |=> state_reg == ST_SCAN && scan_idx_reg == $past(scan_idx_reg) + 1'b1)
        else $error("row scan did not advance by one row");

    a_member_count: assert property (@(posedge clk) disable iff (!rst_n)
        member_count_reg == 5'($countones(set_reg)))
        else $error("member count disagrees with candidate set");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");
`endif

endmodule
